// File: hw/rtl/bir_pkg.sv
// bir_pkg: item types, register indexes and reset values for the bilinear resize block
// no dependencies; used by bilinear_image_resize
`timescale 1ns / 1ps
package bir_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_SIDE_W  = 9;
    localparam int CFG_CH_W    = 3;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

    // reset values of the registers
    localparam logic [CFG_SIDE_W-1:0] RST_SOURCE_WIDTH  = 9'd1;
    localparam logic [CFG_SIDE_W-1:0] RST_SOURCE_HEIGHT = 9'd1;
    localparam logic [CFG_SIDE_W-1:0] RST_TARGET_WIDTH  = 9'd2;
    localparam logic [CFG_SIDE_W-1:0] RST_TARGET_HEIGHT = 9'd2;
    localparam logic [CFG_CH_W-1:0]   RST_CHANNEL_COUNT = 3'd4;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [17:0] load_address;
        logic [7:0]  load_value;
        logic [7:0]  out_x;
        logic [7:0]  out_y;
        logic [1:0]  channel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] sample_value;
        logic       skipped;
    } out_item_t;

endpackage

// File: hw/rtl/bir_ram.sv
// bir_ram: generic single-port synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps
module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/bilinear_image_resize.sv
// bilinear_image_resize: top level, source byte store and bilinear sample datapath
// depends on bir_pkg and bir_ram
`timescale 1ns / 1ps
// usage
//   request channel: an item is taken at a clock edge with start high and busy low.
//   op load writes load_value at load_address (modulo the store depth) and gives
//   no result; op sample gives one result for out_x, out_y and channel.
//   result channel: done is high for exactly one cycle with result valid;
//   the receiver cannot stall, so nothing is ever held back.
//   configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. every write restarts the two ratio dividers
//   (source size << FRAC_BITS by target size): a load step, then one quotient
//   bit per cycle for SW + FRAC_BITS bits; busy stays high meanwhile.
// pipeline and rate
//   five front stages (capture, coordinate multiply, clamp, weight/row multiply,
//   address add), then the single port of the source ram reads the four
//   neighbors one per cycle, then multiply and accumulate give the result.
//   the ram port sets the rate: a sample holds the port for its four neighbor reads
//   and the items behind it wait; one load every cycle while the port is free and
//   the dividers are idle; loads and samples keep their order through the port.
// reset
//   registers go to their reset values and the dividers run once (busy high);
//   the store itself is not cleared and holds garbage until written.
module bilinear_image_resize #(
    parameter int MAX_SIDE     = 256,
    parameter int MAX_CHANNELS = 4,
    parameter int FRAC_BITS    = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  bir_pkg::in_item_t                request,
    output logic                             done,
    output bir_pkg::out_item_t               result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bir_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // widths derived from the parameters
    localparam int CW    = $clog2(MAX_SIDE);              // source coordinate
    localparam int SW    = $clog2(MAX_SIDE + 1);          // source side length
    localparam int CHW   = $clog2(MAX_CHANNELS + 1);      // channel count
    localparam int STW   = SW + CHW;                      // row stride
    localparam int RW    = SW + FRAC_BITS;                // ratio
    localparam int PXW   = RW + 9;                        // ratio times coordinate
    localparam int BXW   = PXW - FRAC_BITS;               // integer part of position
    localparam int WW    = FRAC_BITS + 1;                 // one-axis weight
    localparam int PW    = 2 * FRAC_BITS + 1;             // two-axis weight
    localparam int ACCW  = 2 * FRAC_BITS + 8;             // weighted sum
    localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int DCW   = $clog2(RW + 1);                // divider step count
    localparam int DW    = bir_pkg::CFG_SIDE_W;           // divisor

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [bir_pkg::CFG_SIDE_W-1:0] sw_cfg_reg, sh_cfg_reg, tw_cfg_reg, th_cfg_reg;
    logic [bir_pkg::CFG_CH_W-1:0]   ch_cfg_reg;
    logic                           cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_cfg_reg <= bir_pkg::RST_SOURCE_WIDTH;
            sh_cfg_reg <= bir_pkg::RST_SOURCE_HEIGHT;
            tw_cfg_reg <= bir_pkg::RST_TARGET_WIDTH;
            th_cfg_reg <= bir_pkg::RST_TARGET_HEIGHT;
            ch_cfg_reg <= bir_pkg::RST_CHANNEL_COUNT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bir_pkg::CFG_SOURCE_WIDTH:  sw_cfg_reg <= cfg_data;
                bir_pkg::CFG_SOURCE_HEIGHT: sh_cfg_reg <= cfg_data;
                bir_pkg::CFG_TARGET_WIDTH:  tw_cfg_reg <= cfg_data;
                bir_pkg::CFG_TARGET_HEIGHT: th_cfg_reg <= cfg_data;
                bir_pkg::CFG_CHANNEL_COUNT: ch_cfg_reg <= bir_pkg::CFG_CH_W'(cfg_data);
                default: ;
            endcase
        end
    end

    // effective sizes: zero reads as one, oversize saturates
    logic [SW-1:0]  sw_eff, sh_eff;
    logic [CHW-1:0] ch_eff;
    logic [STW-1:0] stride_reg;

    always_comb
    begin
        if (sw_cfg_reg == '0)
            sw_eff = SW'(1);
        else if (int'(sw_cfg_reg) > MAX_SIDE)
            sw_eff = SW'(MAX_SIDE);
        else
            sw_eff = SW'(sw_cfg_reg);

        if (sh_cfg_reg == '0)
            sh_eff = SW'(1);
        else if (int'(sh_cfg_reg) > MAX_SIDE)
            sh_eff = SW'(MAX_SIDE);
        else
            sh_eff = SW'(sh_cfg_reg);

        if (ch_cfg_reg == '0)
            ch_eff = CHW'(1);
        else if (int'(ch_cfg_reg) > MAX_CHANNELS)
            ch_eff = CHW'(MAX_CHANNELS);
        else
            ch_eff = CHW'(ch_cfg_reg);
    end

    always_ff @(posedge clk)
    begin
        stride_reg <= STW'(sw_eff * ch_eff);
    end

    // ---------------------------------------------------------------
    // ratio dividers, restoring, one quotient bit per cycle
    // index 0 is the x axis, index 1 the y axis
    // ---------------------------------------------------------------
    logic              div_load_reg;
    logic [DCW-1:0]    div_cnt_reg;
    logic [RW-1:0]     div_num_reg [2];
    logic [DW-1:0]     div_rem_reg [2];
    logic [DW:0]       div_shift   [2];
    logic [DW-1:0]     div_den     [2];
    logic              div_busy;

    assign div_den[0] = tw_cfg_reg;
    assign div_den[1] = th_cfg_reg;
    assign div_busy   = div_load_reg || (div_cnt_reg != '0);

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            div_shift[i] = {div_rem_reg[i], div_num_reg[i][RW-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_load_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end
        else if (cfg_write)
        begin
            div_load_reg <= 1'b1;
        end
        else if (div_load_reg)
        begin
            div_load_reg <= 1'b0;
            div_cnt_reg  <= DCW'(RW);
        end
        else if (div_cnt_reg != '0)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // the numerator register shifts the quotient in and ends up as the ratio
    always_ff @(posedge clk)
    begin
        if (div_load_reg)
        begin
            div_num_reg[0] <= {sw_eff, FRAC_BITS'(0)};
            div_num_reg[1] <= {sh_eff, FRAC_BITS'(0)};
            div_rem_reg[0] <= '0;
            div_rem_reg[1] <= '0;
        end
        else if (div_cnt_reg != '0)
        begin
            for (int i = 0; i < 2; i++)
            begin
                if (div_shift[i] >= {1'b0, div_den[i]})
                begin
                    div_rem_reg[i] <= DW'(div_shift[i] - {1'b0, div_den[i]});
                    div_num_reg[i] <= {div_num_reg[i][RW-2:0], 1'b1};
                end
                else
                begin
                    div_rem_reg[i] <= DW'(div_shift[i]);
                    div_num_reg[i] <= {div_num_reg[i][RW-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // front pipeline, all stages move together
    // ---------------------------------------------------------------
    logic adv;
    logic take;
    logic accept;

    logic                a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg;
    bir_pkg::in_item_t   a_item_reg, b_item_reg, c_item_reg, d_item_reg, e_item_reg;

    logic [PXW-1:0]      b_px_reg, b_nx_reg, b_py_reg, b_ny_reg;
    logic [CW-1:0]       c_x0_reg, c_x1_reg, c_y0_reg, c_y1_reg;
    logic [FRAC_BITS-1:0] c_fx_reg, c_fy_reg;
    logic [CW+STW-1:0]   d_r0_reg, d_r1_reg;
    logic [CW+CHW-1:0]   d_c0_reg, d_c1_reg;
    logic [PW-1:0]       d_w_reg [4];
    logic [AW-1:0]       e_addr_reg [4];
    logic [PW-1:0]       e_w_reg [4];
    logic                e_skip_reg;

    assign adv    = !e_vld_reg || take;
    assign busy   = !adv || div_busy;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    // stages c to e combinational: integer parts and clamp limits, weights, byte addresses
    logic [BXW-1:0] bx0, bx1, by0, by1;
    logic [SW-1:0]  x_lim, y_lim;
    logic [WW-1:0]  wx0, wy0, fx_w, fy_w;
    logic [AW:0]    sum_addr [4];
    logic [AW:0]    row_a    [4];
    logic [AW:0]    col_a    [4];

    always_comb
    begin
        bx0   = b_px_reg[PXW-1:FRAC_BITS];
        bx1   = b_nx_reg[PXW-1:FRAC_BITS];
        by0   = b_py_reg[PXW-1:FRAC_BITS];
        by1   = b_ny_reg[PXW-1:FRAC_BITS];
        x_lim = sw_eff - 1'b1;
        y_lim = sh_eff - 1'b1;
        fx_w  = {1'b0, c_fx_reg};
        fy_w  = {1'b0, c_fy_reg};
        wx0   = {1'b1, FRAC_BITS'(0)} - fx_w;
        wy0   = {1'b1, FRAC_BITS'(0)} - fy_w;

        // neighbor order: (y0,x0) (y0,x1) (y1,x0) (y1,x1)
        row_a[0] = (AW+1)'(d_r0_reg);
        row_a[1] = (AW+1)'(d_r0_reg);
        row_a[2] = (AW+1)'(d_r1_reg);
        row_a[3] = (AW+1)'(d_r1_reg);
        col_a[0] = (AW+1)'(d_c0_reg);
        col_a[1] = (AW+1)'(d_c1_reg);
        col_a[2] = (AW+1)'(d_c0_reg);
        col_a[3] = (AW+1)'(d_c1_reg);
        for (int k = 0; k < 4; k++)
        begin
            sum_addr[k] = row_a[k] + col_a[k] + (AW+1)'(d_item_reg.channel);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= request;

            // b: position along each axis
            b_item_reg <= a_item_reg;
            b_px_reg   <= PXW'(div_num_reg[0] * a_item_reg.out_x);
            b_nx_reg   <= PXW'(div_num_reg[0] * ({1'b0, a_item_reg.out_x} + 9'd1));
            b_py_reg   <= PXW'(div_num_reg[1] * a_item_reg.out_y);
            b_ny_reg   <= PXW'(div_num_reg[1] * ({1'b0, a_item_reg.out_y} + 9'd1));

            // c: clamp and fractions
            c_item_reg <= b_item_reg;
            c_x0_reg   <= (bx0 > BXW'(x_lim)) ? CW'(x_lim) : CW'(bx0);
            c_x1_reg   <= (bx1 > BXW'(x_lim)) ? CW'(x_lim) : CW'(bx1);
            c_y0_reg   <= (by0 > BXW'(y_lim)) ? CW'(y_lim) : CW'(by0);
            c_y1_reg   <= (by1 > BXW'(y_lim)) ? CW'(y_lim) : CW'(by1);
            c_fx_reg   <= b_px_reg[FRAC_BITS-1:0];
            c_fy_reg   <= b_py_reg[FRAC_BITS-1:0];

            // d: row offsets, column offsets and the four weights
            d_item_reg <= c_item_reg;
            d_r0_reg   <= (CW+STW)'(c_y0_reg * stride_reg);
            d_r1_reg   <= (CW+STW)'(c_y1_reg * stride_reg);
            d_c0_reg   <= (CW+CHW)'(c_x0_reg * ch_eff);
            d_c1_reg   <= (CW+CHW)'(c_x1_reg * ch_eff);
            d_w_reg[0] <= PW'(wx0 * wy0);
            d_w_reg[1] <= PW'(fx_w * wy0);
            d_w_reg[2] <= PW'(wx0 * fy_w);
            d_w_reg[3] <= PW'(fx_w * fy_w);

            // e: byte addresses, wrapped into the store
            e_item_reg <= d_item_reg;
            e_skip_reg <= (tw_cfg_reg <= 9'd1) || (th_cfg_reg <= 9'd1);
            for (int k = 0; k < 4; k++)
            begin
                e_w_reg[k] <= d_w_reg[k];
                if (sum_addr[k] >= (AW+1)'(DEPTH))
                    e_addr_reg[k] <= AW'(sum_addr[k] - (AW+1)'(DEPTH));
                else
                    e_addr_reg[k] <= AW'(sum_addr[k]);
            end
        end
    end

    // ---------------------------------------------------------------
    // source ram port sequencer
    // ---------------------------------------------------------------
    logic              m_active_reg;
    logic [1:0]        m_cnt_reg;
    logic [AW-1:0]     m_addr_reg [4];
    logic [PW-1:0]     m_w_reg    [4];
    logic              m_skip_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [7:0]        ram_rdata;
    logic              iss_vld, iss_first, iss_last, iss_skip;
    logic [PW-1:0]     iss_w;

    assign take = e_vld_reg && !m_active_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = m_addr_reg[m_cnt_reg];
        iss_vld   = 1'b0;
        iss_first = 1'b0;
        iss_last  = 1'b0;
        iss_skip  = m_skip_reg;
        iss_w     = m_w_reg[m_cnt_reg];
        if (take)
        begin
            if (e_item_reg.op == bir_pkg::OP_LOAD)
            begin
                ram_we   = 1'b1;
                ram_addr = AW'(e_item_reg.load_address);
            end
            else
            begin
                ram_addr  = e_addr_reg[0];
                iss_vld   = 1'b1;
                iss_first = 1'b1;
                iss_skip  = e_skip_reg;
                iss_w     = e_w_reg[0];
            end
        end
        else if (m_active_reg)
        begin
            iss_vld  = 1'b1;
            iss_last = (m_cnt_reg == 2'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_active_reg <= 1'b0;
            m_cnt_reg    <= '0;
        end
        else if (take && (e_item_reg.op == bir_pkg::OP_SAMPLE))
        begin
            m_active_reg <= 1'b1;
            m_cnt_reg    <= 2'd1;
        end
        else if (m_active_reg)
        begin
            m_cnt_reg <= m_cnt_reg + 2'd1;
            if (m_cnt_reg == 2'd3)
                m_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            m_addr_reg <= e_addr_reg;
            m_w_reg    <= e_w_reg;
            m_skip_reg <= e_skip_reg;
        end
    end

    bir_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (e_item_reg.load_value),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // multiply and accumulate
    // ---------------------------------------------------------------
    logic              iss_vld_reg, iss_first_reg, iss_last_reg, iss_skip_reg;
    logic [PW-1:0]     iss_w_reg;
    logic              p_vld_reg, p_first_reg, p_last_reg, p_skip_reg;
    logic [ACCW-1:0]   p_prod_reg;
    logic [ACCW-1:0]   acc_reg;
    logic [ACCW-1:0]   acc_next;
    logic              done_reg;
    bir_pkg::out_item_t result_reg;

    assign acc_next = (p_first_reg ? '0 : acc_reg) + p_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_vld_reg <= 1'b0;
            p_vld_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            iss_vld_reg <= iss_vld;
            p_vld_reg   <= iss_vld_reg;
            done_reg    <= p_vld_reg && p_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_first_reg <= iss_first;
        iss_last_reg  <= iss_last;
        iss_skip_reg  <= iss_skip;
        iss_w_reg     <= iss_w;

        p_first_reg <= iss_first_reg;
        p_last_reg  <= iss_last_reg;
        p_skip_reg  <= iss_skip_reg;
        p_prod_reg  <= ACCW'(ram_rdata * iss_w_reg);

        if (p_vld_reg)
        begin
            acc_reg <= acc_next;
        end
        if (p_vld_reg && p_last_reg)
        begin
            result_reg.sample_value <= p_skip_reg ? 8'd0 : acc_next[ACCW-1:ACCW-8];
            result_reg.skipped      <= p_skip_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    // a skipped sample carries a zero byte
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!result.skipped || (result.sample_value == 8'd0)))
        else $error("skipped result with nonzero value");

    // the last neighbor read leads to a result through the product and done registers
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (iss_vld_reg && iss_last_reg) |-> ##2 done)
        else $error("result missing after last neighbor read");

    // no store write while a sample owns the ram port
    a_no_write_mid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !m_active_reg)
        else $error("store write during neighbor reads");

    // no request accepted while ratios are being computed
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) |-> !accept)
        else $error("item accepted during ratio update");
`endif

endmodule

// File: tb/bilinear_image_resize_tb.sv
// bilinear_image_resize_tb: self-checking testbench for the bilinear resize block
// depends on bir_pkg and bilinear_image_resize; loads source bytes, then checks sampled bytes
// against a cycle-free predictor, with random start gaps and register phases
`timescale 1ns / 1ps
module bilinear_image_resize_tb;

    localparam int STORE_DEPTH  = 262144;
    localparam int FRAC         = 16;
    localparam int WATCH_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    bir_pkg::in_item_t               request;
    logic                            done;
    bir_pkg::out_item_t              result;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [bir_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bir_pkg::CFG_DATA_W-1:0]  cfg_data;

    bilinear_image_resize uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: shadow of the source store and of the registers
    logic [7:0]      shadow_store [STORE_DEPTH];
    bit              byte_loaded  [STORE_DEPTH];
    logic [8:0]      reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
    logic [2:0]      reg_chans;

    bir_pkg::in_item_t  pending_items [$];
    bir_pkg::out_item_t expected_samples [$];
    bit              item_taken;
    int              items_taken;
    int              mismatches;
    int              results_seen;
    int              load_count, sample_count, skip_count, phase_count;
    int              idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // fitted size: zero reads as one, oversize saturates
    function automatic longint unsigned fit_size(longint unsigned v, longint unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // maps one output coordinate onto a source axis
    task automatic map_axis(input longint unsigned src, input longint unsigned dst,
                            input longint unsigned c, output longint unsigned p0,
                            output longint unsigned p1, output longint unsigned frac);
        longint unsigned ratio, pos, nxt;
        ratio = (src << FRAC) / dst;
        pos   = ratio * c;
        nxt   = (ratio * (c + 1)) >> FRAC;
        frac  = pos & ((64'd1 << FRAC) - 1);
        p0    = ((pos >> FRAC) > src - 1) ? src - 1 : (pos >> FRAC);
        p1    = (nxt > src - 1) ? src - 1 : nxt;
    endtask

    task automatic queue_load(input logic [17:0] addr, input logic [7:0] val);
        bir_pkg::in_item_t it;
        it = '0;
        it.op           = bir_pkg::OP_LOAD;
        it.load_address = addr;
        it.load_value   = val;
        it.out_x        = 8'($urandom);
        it.out_y        = 8'($urandom);
        it.channel      = 2'($urandom);
        pending_items.push_back(it);
        shadow_store[addr] = val;
        byte_loaded[addr]  = 1'b1;
        load_count++;
    endtask

    // queues a sample; any neighbor byte never loaded gets a load first
    task automatic queue_sample(input logic [7:0] x, input logic [7:0] y, input logic [1:0] c);
        bir_pkg::in_item_t  it;
        bir_pkg::out_item_t exp_item;
        longint unsigned sw, sh, ch, stride, x0, x1, fx, y0, y1, fy, sum;
        longint unsigned rows [2];
        longint unsigned cols [2];
        longint unsigned wts [4];
        logic [17:0]     addr [4];
        it = '0;
        it.op           = bir_pkg::OP_SAMPLE;
        it.load_address = 18'($urandom);
        it.load_value   = 8'($urandom);
        it.out_x        = x;
        it.out_y        = y;
        it.channel      = c;
        exp_item = '0;
        if (reg_dst_w <= 1 || reg_dst_h <= 1)
        begin
            exp_item.skipped = 1'b1;
            skip_count++;
        end
        else
        begin
            sw = fit_size(reg_src_w, 256);
            sh = fit_size(reg_src_h, 256);
            ch = fit_size(reg_chans, 4);
            stride = sw * ch;
            map_axis(sw, reg_dst_w, x, x0, x1, fx);
            map_axis(sh, reg_dst_h, y, y0, y1, fy);
            rows[0] = y0; rows[1] = y1;
            cols[0] = x0; cols[1] = x1;
            for (int k = 0; k < 4; k++)
            begin
                addr[k] = 18'(rows[k / 2] * stride + cols[k % 2] * ch + c);
                if (!byte_loaded[addr[k]])
                    queue_load(addr[k], 8'($urandom));
            end
            wts[0] = ((64'd1 << FRAC) - fx) * ((64'd1 << FRAC) - fy);
            wts[1] = fx * ((64'd1 << FRAC) - fy);
            wts[2] = ((64'd1 << FRAC) - fx) * fy;
            wts[3] = fx * fy;
            sum = 0;
            for (int k = 0; k < 4; k++)
                sum += shadow_store[addr[k]] * wts[k];
            exp_item.sample_value = 8'(sum >> (2 * FRAC));
        end
        pending_items.push_back(it);
        expected_samples.push_back(exp_item);
        sample_count++;
    endtask

    task automatic write_reg(input logic [bir_pkg::CFG_INDEX_W-1:0] idx, input logic [8:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            bir_pkg::CFG_SOURCE_WIDTH:  reg_src_w = val;
            bir_pkg::CFG_SOURCE_HEIGHT: reg_src_h = val;
            bir_pkg::CFG_TARGET_WIDTH:  reg_dst_w = val;
            bir_pkg::CFG_TARGET_HEIGHT: reg_dst_h = val;
            bir_pkg::CFG_CHANNEL_COUNT: reg_chans = val[2:0];
            default: ;
        endcase
    endtask

    // block must be idle: queue drained, results in, then the pipeline settles
    task automatic drain;
        wait (pending_items.size() == 0 && expected_samples.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_phase(input logic [8:0] sw, input logic [8:0] sh, input logic [8:0] tw,
                             input logic [8:0] th, input logic [2:0] ch);
        drain();
        write_reg(bir_pkg::CFG_SOURCE_WIDTH, sw);
        write_reg(bir_pkg::CFG_SOURCE_HEIGHT, sh);
        write_reg(bir_pkg::CFG_TARGET_WIDTH, tw);
        write_reg(bir_pkg::CFG_TARGET_HEIGHT, th);
        write_reg(bir_pkg::CFG_CHANNEL_COUNT, {6'd0, ch});
        phase_count++;
    endtask

    // random traffic: mostly samples with their loads, some stray loads
    task automatic random_traffic(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 15)
                queue_load(18'($urandom), 8'($urandom));
            else if ($urandom_range(3) == 0)
                queue_sample(8'($urandom_range(1, 0) ? 8'd255 : 8'd0) ^ 8'($urandom),
                             8'($urandom), 2'($urandom));
            else
                queue_sample(8'($urandom_range(reg_dst_w > 255 ? 255 : reg_dst_w)),
                             8'($urandom_range(reg_dst_h > 255 ? 255 : reg_dst_h)),
                             2'($urandom));
        end
    endtask

    // stimulus
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reg_src_w = bir_pkg::RST_SOURCE_WIDTH;
        reg_src_h = bir_pkg::RST_SOURCE_HEIGHT;
        reg_dst_w = bir_pkg::RST_TARGET_WIDTH;
        reg_dst_h = bir_pkg::RST_TARGET_HEIGHT;
        reg_chans = bir_pkg::RST_CHANNEL_COUNT;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, under reset values: field extremes, store ends, edge clamps
        queue_load(18'h00000, 8'h00);
        queue_load(18'h3FFFF, 8'hFF);
        queue_load(18'h00001, 8'hFF);
        queue_load(18'h00002, 8'h80);
        queue_load(18'h00003, 8'h7F);
        queue_sample(8'd0, 8'd0, 2'd0);
        queue_sample(8'd1, 8'd1, 2'd1);
        queue_sample(8'd255, 8'd255, 2'd3);
        queue_sample(8'd255, 8'd0, 2'd2);
        set_phase(9'd4, 9'd3, 9'd7, 9'd5, 3'd3);
        queue_sample(8'd0, 8'd0, 2'd0);
        queue_sample(8'd6, 8'd4, 2'd2);
        queue_sample(8'd200, 8'd3, 2'd3);     // channel past count
        queue_sample(8'd3, 8'd255, 2'd1);     // row past target
        set_phase(9'd16, 9'd8, 9'd1, 9'd8, 3'd2);  // skipped, width too small
        queue_sample(8'd0, 8'd0, 2'd0);
        queue_sample(8'd255, 8'd255, 2'd3);
        set_phase(9'd16, 9'd8, 9'd8, 9'd0, 3'd2);  // skipped, zero height
        queue_sample(8'd5, 8'd1, 2'd1);

        // register phases with random traffic, extremes among them
        set_phase(9'd256, 9'd256, 9'd256, 9'd256, 3'd4);
        random_traffic(50);
        set_phase(9'd0, 9'd0, 9'd2, 9'd2, 3'd0);
        random_traffic(90);
        set_phase(9'd511, 9'd300, 9'd511, 9'd400, 3'd7);
        random_traffic(50);
        set_phase(9'd5, 9'd3, 9'd17, 9'd11, 3'd3);
        random_traffic(100);
        set_phase(9'd1, 9'd1, 9'd256, 9'd256, 3'd1);
        random_traffic(90);
        set_phase(9'd200, 9'd100, 9'd3, 9'd2, 3'd2);
        random_traffic(110);
        set_phase(9'd7, 9'd9, 9'd1, 9'd1, 3'd1);
        random_traffic(40);
        set_phase(9'd33, 9'd64, 9'd12, 9'd300, 3'd4);
        random_traffic(50);

        drain();
        $display("covered %0d register phases, %0d byte loads, %0d samples (%0d skipped)",
                 phase_count, load_count, sample_count, skip_count);
        $display("checked %0d results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // driver: holds start until the item is taken, then pops it
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_taken)
                void'(pending_items.pop_front());
            if (start && !item_taken)
                start <= 1'b1;
            else if (pending_items.size() > 0 &&
                     ((items_taken >= 400 && items_taken < 560) || $urandom_range(99) >= 34))
            begin
                start   <= 1'b1;
                request <= pending_items[0];
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: takes the request handshake and checks every result strobe
    always @(posedge clk)
    begin
        item_taken = rst_n && start && !busy;
        if (item_taken)
            items_taken++;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_samples.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                bir_pkg::out_item_t e;
                e = expected_samples.pop_front();
                if (result.sample_value !== e.sample_value)
                    report_mismatch($sformatf("sample_value got %0d want %0d",
                                              result.sample_value, e.sample_value));
                if (result.skipped !== e.skipped)
                    report_mismatch($sformatf("skipped got %0b want %0b",
                                              result.skipped, e.skipped));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || item_taken || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("timeout: %0d items pending, %0d results outstanding",
                     pending_items.size(), expected_samples.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        item_taken   = 1'b0;
        items_taken  = 0;
        mismatches   = 0;
        results_seen = 0;
        load_count   = 0;
        sample_count = 0;
        skip_count   = 0;
        phase_count  = 0;
        idle_cycles  = 0;
    end

endmodule

// File: filelist.f
hw/rtl/bir_pkg.sv
hw/rtl/bir_ram.sv
hw/rtl/bilinear_image_resize.sv
tb/bilinear_image_resize_tb.sv
